/* hdl/mwnco_pkg.sv */
// Shared constants, register codes and the sine table generator for the
// multi-waveform NCO. No dependencies.
`default_nettype none

package mwnco_pkg;

  localparam int PHASE_BITS_DEF      = 32;
  localparam int SINE_TABLE_BITS_DEF = 10;
  localparam int SAMPLE_BITS_DEF     = 16;

  localparam int LFO_W      = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;
  localparam int STEP_W     = 32;
  localparam int FMD_W      = 32;
  localparam int PW_W       = 17;
  localparam int PWD_W      = 18;

  localparam logic [PW_W-1:0] PULSE_WIDTH_RST = 17'd32768;
  localparam logic [PW_W-1:0] PULSE_WIDTH_MAX = 17'd65536;

  localparam longint unsigned PIH_Q30 = 64'd1686629713;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WAVE_SELECT    = 3'd0,
    REG_LFO_ENABLE     = 3'd1,
    REG_PHASE_STEP     = 3'd2,
    REG_FREQ_MOD_DEPTH = 3'd3,
    REG_PULSE_WIDTH    = 3'd4,
    REG_PW_MOD_DEPTH   = 3'd5
  } cfg_reg_t;

  typedef enum logic [1:0] {
    WAVE_SAW      = 2'd0,
    WAVE_TRIANGLE = 2'd1,
    WAVE_PULSE    = 2'd2,
    WAVE_SINE     = 2'd3
  } wave_t;

  // quarter-wave sine entry k of a table with 2^stb steps, scaled to 2^(sb-1)-1
  function automatic longint sine_entry(input int k, input int stb, input int sb);
    longint unsigned x;
    longint unsigned x2;
    longint unsigned term;
    longint s;
    longint e;
    longint top;
    top  = (64'sd1 <<< (sb - 1)) - 64'sd1;
    x    = (PIH_Q30 * 64'(k)) >> stb;
    x2   = (x * x) >> 30;
    term = x;
    s    = 0;
    for (int n = 0; n < 12; n++) begin
      if ((n & 1) != 0) begin
        s = s - longint'(term);
      end else begin
        s = s + longint'(term);
      end
      term = (term * x2) >> 30;
      term = term / 64'((2 * n + 2) * (2 * n + 3));
    end
    if (s < 0) begin
      s = 0;
    end
    e = (s * top + (64'sd1 <<< 29)) >>> 30;
    if (e > top) begin
      e = top;
    end
    return e;
  endfunction

endpackage

`default_nettype wire

/* hdl/mwnco_if.sv */
// Valid/ready channel interfaces for the NCO: LFO word in, sample word out.
// Depends on mwnco_pkg.
`default_nettype none

interface mwnco_lfo_if;
  logic                                valid;
  logic                                ready;
  logic signed [mwnco_pkg::LFO_W-1:0]  lfo_value;

  modport source (output valid, output lfo_value, input ready);
  modport sink   (input valid, input lfo_value, output ready);
endinterface

interface mwnco_sample_if #(
  parameter int SAMPLE_BITS = mwnco_pkg::SAMPLE_BITS_DEF
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample_out;

  modport source (output valid, output sample_out, input ready);
  modport sink   (input valid, input sample_out, output ready);
endinterface

`default_nettype wire

/* hdl/multi_waveform_nco_unit.sv */
// Multi-waveform NCO top level: phase accumulator, LFO modulation, waveform
// shaping. Depends on mwnco_pkg, mwnco_if and mwnco_sine_rom.
//
//   channel  | direction | word                    | handshake
//   in_ch    | in        | lfo_value, Q1.15        | valid/ready
//   out_ch   | out       | sample_out, Q1.(SB-1)   | valid/ready
//   cfg_*    | in        | index + 32-bit data     | write enable only
//
// One word per clock sustained while out_ch does not stall.
// Stages: input register, LFO products, phase accumulator update, waveform
// shaping with sine ROM read, output register. The accumulator add is the loop.
// rst_n is synchronous; it clears the pipeline, phase and registers.
// A stall at out_ch fills empty stages first; in_ch.ready drops only when full.
`default_nettype none

module multi_waveform_nco_unit #(
  parameter int PHASE_BITS      = mwnco_pkg::PHASE_BITS_DEF,
  parameter int SINE_TABLE_BITS = mwnco_pkg::SINE_TABLE_BITS_DEF,
  parameter int SAMPLE_BITS     = mwnco_pkg::SAMPLE_BITS_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  mwnco_lfo_if.sink                                in_ch,
  mwnco_sample_if.source                           out_ch,
  input  wire logic                                cfg_we,
  input  wire logic [mwnco_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [mwnco_pkg::CFG_DATA_W-1:0]    cfg_data
);

  localparam int PB  = PHASE_BITS;
  localparam int STB = SINE_TABLE_BITS;
  localparam int SB  = SAMPLE_BITS;
  localparam int IW  = 34;
  localparam int UP  = (PB >= 32) ? (PB - 32) : 0;
  localparam int DN  = (PB >= 32) ? 0 : (32 - PB);
  localparam int DW  = IW + UP;
  localparam int ZW  = SB + STB + 2;
  localparam int XW  = PB + ZW;

  localparam logic [SB-1:0]  S_MAX = {1'b0, {(SB-1){1'b1}}};
  localparam logic [SB-1:0]  S_MIN = {1'b1, {(SB-1){1'b0}}};
  localparam logic [SB+1:0]  M_W   = (SB+2)'(1) << (SB - 1);
  localparam logic [STB:0]   TAB_N = (STB+1)'(1) << STB;

  // configuration
  mwnco_pkg::wave_t                          wave_sel_r;
  logic                                      lfo_en_r;
  logic [mwnco_pkg::STEP_W-1:0]              phase_step_r;
  logic signed [mwnco_pkg::FMD_W-1:0]        fm_depth_r;
  logic [mwnco_pkg::PW_W-1:0]                pulse_width_r;
  logic signed [mwnco_pkg::PWD_W-1:0]        pwm_depth_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wave_sel_r    <= mwnco_pkg::WAVE_SAW;
      lfo_en_r      <= 1'b0;
      phase_step_r  <= '0;
      fm_depth_r    <= '0;
      pulse_width_r <= mwnco_pkg::PULSE_WIDTH_RST;
      pwm_depth_r   <= '0;
    end else if (cfg_we) begin
      case (mwnco_pkg::cfg_reg_t'(cfg_index))
        mwnco_pkg::REG_WAVE_SELECT:    wave_sel_r    <= mwnco_pkg::wave_t'(cfg_data[1:0]);
        mwnco_pkg::REG_LFO_ENABLE:     lfo_en_r      <= cfg_data[0];
        mwnco_pkg::REG_PHASE_STEP:     phase_step_r  <= cfg_data[mwnco_pkg::STEP_W-1:0];
        mwnco_pkg::REG_FREQ_MOD_DEPTH: fm_depth_r    <= cfg_data[mwnco_pkg::FMD_W-1:0];
        mwnco_pkg::REG_PULSE_WIDTH:    pulse_width_r <= cfg_data[mwnco_pkg::PW_W-1:0];
        mwnco_pkg::REG_PW_MOD_DEPTH:   pwm_depth_r   <= cfg_data[mwnco_pkg::PWD_W-1:0];
        default: ;
      endcase
    end
  end

  // pipeline flow control
  logic v0_r, v1_r, v2_r, v3_r, v4_r;
  logic mv0, mv1, mv2, mv3;
  logic in_acc;

  assign mv3    = v3_r && (!v4_r || out_ch.ready);
  assign mv2    = v2_r && (!v3_r || mv3);
  assign mv1    = v1_r && (!v2_r || mv2);
  assign mv0    = v0_r && (!v1_r || mv1);
  assign in_ch.ready = !v0_r || mv0;
  assign in_acc = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      v0_r <= in_acc || (v0_r && !mv0);
      v1_r <= mv0 || (v1_r && !mv1);
      v2_r <= mv1 || (v2_r && !mv2);
      v3_r <= mv2 || (v3_r && !mv3);
      v4_r <= mv3 || (v4_r && !out_ch.ready);
    end
  end

  // input register
  logic signed [mwnco_pkg::LFO_W-1:0] lfo0_r;

  always_ff @(posedge clk) begin
    if (in_acc) begin
      lfo0_r <= in_ch.lfo_value;
    end
  end

  // LFO products, floor-scaled by 2^-15
  logic signed [mwnco_pkg::LFO_W-1:0] lfo_eff;
  logic signed [47:0]                 fm_prod;
  logic signed [33:0]                 pw_prod;
  logic signed [32:0]                 fm_off1_r;
  logic signed [18:0]                 pw_off1_r;

  assign lfo_eff = lfo_en_r ? lfo0_r : '0;
  assign fm_prod = 48'(fm_depth_r) * 48'(lfo_eff);
  assign pw_prod = 34'(pwm_depth_r) * 34'(lfo_eff);

  always_ff @(posedge clk) begin
    if (mv0) begin
      fm_off1_r <= $signed(fm_prod[47:15]);
      pw_off1_r <= $signed(pw_prod[33:15]);
    end
  end

  // phase accumulator and pulse width
  logic signed [IW-1:0] inc;
  logic signed [DW-1:0] d_w;
  logic signed [19:0]   pw_sum;
  logic [PB-1:0]        phase_acc_r;
  logic [PB-1:0]        ph2_r;
  logic [mwnco_pkg::PW_W-1:0] pw_sat;
  logic [mwnco_pkg::PW_W-1:0] pw2_r;

  assign inc    = $signed({2'b00, phase_step_r}) + IW'(fm_off1_r);
  assign d_w    = (DW'(inc) <<< UP) >>> DN;
  assign pw_sum = $signed({3'b000, pulse_width_r}) + 20'(pw_off1_r);

  always_comb begin
    if (pw_sum < 0) begin
      pw_sat = '0;
    end else if (pw_sum > $signed({3'b000, mwnco_pkg::PULSE_WIDTH_MAX})) begin
      pw_sat = mwnco_pkg::PULSE_WIDTH_MAX;
    end else begin
      pw_sat = pw_sum[mwnco_pkg::PW_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_acc_r <= '0;
    end else if (mv1) begin
      phase_acc_r <= phase_acc_r + d_w[PB-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (mv1) begin
      ph2_r <= phase_acc_r;
      pw2_r <= pw_sat;
    end
  end

  // waveform shaping
  logic [XW-1:0]         phx;
  logic [SB-1:0]         saw_top;
  logic [SB:0]           tri_top;
  logic signed [SB:0]    tri_q;
  logic [SB:0]           tri_abs;
  logic signed [SB+1:0]  tri_w;
  logic [SB-1:0]         tri_v;
  logic                  pulse_hi;
  logic [STB+1:0]        sin_q;
  logic [STB:0]          rom_addr;
  logic [SB-1:0]         val3_nxt;
  mwnco_pkg::wave_t      sel3_r;
  logic [SB-1:0]         val3_r;
  logic                  neg3_r;
  logic [SB-1:0]         rom_data;

  assign phx      = {ph2_r, {ZW{1'b0}}};
  assign saw_top  = phx[XW-1 -: SB];
  assign tri_top  = phx[XW-1 -: SB+1];
  assign tri_q    = $signed({~tri_top[SB], tri_top[SB-1:0]});
  assign tri_abs  = (tri_q < 0) ? (SB+1)'(-tri_q) : tri_q;
  assign tri_w    = $signed(M_W) - $signed({1'b0, tri_abs});
  assign tri_v    = (tri_w == $signed(M_W)) ? S_MAX : tri_w[SB-1:0];
  assign pulse_hi = {1'b0, ph2_r} < ((PB+1)'(pw2_r) << (PB - 16));
  assign sin_q    = phx[XW-1 -: STB+2];
  assign rom_addr = sin_q[STB] ? (TAB_N - {1'b0, sin_q[STB-1:0]}) : {1'b0, sin_q[STB-1:0]};

  always_comb begin
    case (wave_sel_r)
      mwnco_pkg::WAVE_SAW:      val3_nxt = {~saw_top[SB-1], saw_top[SB-2:0]};
      mwnco_pkg::WAVE_TRIANGLE: val3_nxt = tri_v;
      mwnco_pkg::WAVE_PULSE:    val3_nxt = pulse_hi ? S_MAX : S_MIN;
      default:                  val3_nxt = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mv2) begin
      sel3_r <= wave_sel_r;
      val3_r <= val3_nxt;
      neg3_r <= sin_q[STB+1];
    end
  end

  mwnco_sine_rom #(
    .SINE_TABLE_BITS (STB),
    .SAMPLE_BITS     (SB)
  ) u_sine_rom (
    .clk     (clk),
    .rd_en   (mv2),
    .rd_addr (rom_addr),
    .rd_data (rom_data)
  );

  // output register
  logic [SB-1:0] out_r;

  always_ff @(posedge clk) begin
    if (mv3) begin
      if (sel3_r == mwnco_pkg::WAVE_SINE) begin
        out_r <= neg3_r ? (SB'(0) - rom_data) : rom_data;
      end else begin
        out_r <= val3_r;
      end
    end
  end

  assign out_ch.valid      = v4_r;
  assign out_ch.sample_out = out_r;

endmodule

`default_nettype wire

/* hdl/mwnco_sine_rom.sv */
// Quarter-wave sine ROM with registered read, contents built at elaboration.
// Depends on mwnco_pkg.
`default_nettype none

module mwnco_sine_rom #(
  parameter int SINE_TABLE_BITS = mwnco_pkg::SINE_TABLE_BITS_DEF,
  parameter int SAMPLE_BITS     = mwnco_pkg::SAMPLE_BITS_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rd_en,
  input  wire logic [SINE_TABLE_BITS:0]   rd_addr,
  output logic      [SAMPLE_BITS-1:0]     rd_data
);

  localparam int DEPTH = (2 ** SINE_TABLE_BITS) + 1;

  typedef logic [SAMPLE_BITS-1:0] rom_t [DEPTH];

  function automatic rom_t build_rom();
    rom_t t;
    for (int k = 0; k < DEPTH; k++) begin
      t[k] = SAMPLE_BITS'(mwnco_pkg::sine_entry(k, SINE_TABLE_BITS, SAMPLE_BITS));
    end
    return t;
  endfunction

  localparam rom_t ROM = build_rom();

  logic [SAMPLE_BITS-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= ROM[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

/* hdl/mwnco_checker.sv */
// Port-level checks for multi_waveform_nco_unit, attached by bind.
// Depends on the top level's channel interfaces.
`default_nettype none

module mwnco_checker (
  input wire logic clk,
  input wire logic rst_n,
  input wire logic in_valid,
  input wire logic in_ready,
  input wire logic out_valid,
  input wire logic out_ready
);

  localparam logic [2:0] PIPE_DEPTH = 3'd5;

  logic       in_acc;
  logic       out_acc;
  logic [2:0] cnt_r;

  assign in_acc  = in_valid && in_ready;
  assign out_acc = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (in_acc && !out_acc) begin
      cnt_r <= cnt_r + 3'd1;
    end else if (out_acc && !in_acc) begin
      cnt_r <= cnt_r - 3'd1;
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("out valid dropped while stalled");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with no word waiting at output");

  a_in_flight_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= PIPE_DEPTH)
    else $error("more words in flight than pipeline stages");

  a_no_spurious_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> cnt_r != 3'd0)
    else $error("output word with no accepted input");

endmodule

bind multi_waveform_nco_unit mwnco_checker u_mwnco_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready)
);

`default_nettype wire

/* tb/multi_waveform_nco_unit_tb.sv */
// Self-checking bench for multi_waveform_nco_unit: drives LFO words, predicts every
// oscillator sample in a scoreboard class and compares samples in arrival order.
// Depends on mwnco_pkg, mwnco_if and the unit itself.
`timescale 1ns / 100ps

module multi_waveform_nco_unit_tb;
  import mwnco_pkg::*;

  localparam int LATENCY = 5;
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int SETTINGS_RUN = 24;
  localparam int WORDS_PER_SETTING = 70;
  localparam int REPORT_MAX = 10;
  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

  class nco_sample_ledger;
    wave_t wave;
    bit lfo_on;
    bit [31:0] step;
    bit signed [31:0] fm_depth;
    bit [16:0] pw_base;
    bit signed [17:0] pw_depth;
    bit [31:0] phase;
    int quarter_sine [0:1024];
    logic signed [15:0] pending_samples [$];
    int mismatches;

    function new();
      wave = WAVE_SAW;
      lfo_on = 1'b0;
      step = '0;
      fm_depth = '0;
      pw_base = PULSE_WIDTH_RST;
      pw_depth = '0;
      phase = '0;
      mismatches = 0;
      build_sine();
    endfunction

    function void build_sine();
      longint unsigned ang, ang_sq, term;
      longint acc, scaled;
      for (int k = 0; k <= 1024; k++) begin
        ang = (HALF_PI_Q30 * 64'(k)) >> 10;
        ang_sq = (ang * ang) >> 30;
        term = ang;
        acc = 0;
        for (int n = 0; n < 12; n++) begin
          acc = n[0] ? acc - longint'(term) : acc + longint'(term);
          term = ((term * ang_sq) >> 30) / 64'((2 * n + 2) * (2 * n + 3));
        end
        if (acc < 0) acc = 0;
        scaled = (acc * 32767 + (64'sd1 <<< 29)) >>> 30;
        quarter_sine[k] = (scaled > 32767) ? 32767 : int'(scaled);
      end
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] data);
      case (idx)
        REG_WAVE_SELECT: wave = wave_t'(data[1:0]);
        REG_LFO_ENABLE: lfo_on = data[0];
        REG_PHASE_STEP: step = data;
        REG_FREQ_MOD_DEPTH: fm_depth = data;
        REG_PULSE_WIDTH: pw_base = data[16:0];
        REG_PW_MOD_DEPTH: pw_depth = data[17:0];
        default: ;
      endcase
    endfunction

    function void take_lfo_word(logic signed [15:0] lfo);
      longint inc, width;
      logic [11:0] sidx;
      int v, q, idx;
      inc = longint'(step);
      width = longint'(pw_base);
      if (lfo_on) begin
        inc = inc + ((longint'(fm_depth) * longint'(lfo)) >>> 15);
        width = width + ((longint'(pw_depth) * longint'(lfo)) >>> 15);
      end
      if (width < 0) width = 0;
      if (width > 65536) width = 65536;
      case (wave)
        WAVE_SAW: v = int'(phase[31:16]) - 32768;
        WAVE_TRIANGLE: begin
          q = int'(phase[31:15]) - 65536;
          v = 32768 - ((q < 0) ? -q : q);
          if (v > 32767) v = 32767;
        end
        WAVE_PULSE: v = (longint'(phase) < (width <<< 16)) ? 32767 : -32768;
        default: begin
          sidx = phase[31:20];
          idx = sidx[10] ? 1024 - int'(sidx[9:0]) : int'(sidx[9:0]);
          v = quarter_sine[idx];
          if (sidx[11]) v = -v;
        end
      endcase
      phase = phase + inc[31:0];
      pending_samples.push_back(16'(v));
    endfunction

    function void check_sample_word(logic signed [15:0] got);
      logic signed [15:0] want;
      if (pending_samples.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_MAX)
          $display("sample_out %0d arrived with no sample pending", got);
        return;
      end
      want = pending_samples.pop_front();
      if (got !== want) begin
        mismatches++;
        if (mismatches <= REPORT_MAX)
          $display("sample_out mismatch: expected %0d, got %0d", want, got);
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int unsigned cycles = 0;
  nco_sample_ledger ledger;

  mwnco_lfo_if lfo_ch();
  mwnco_sample_if sample_ch();

  multi_waveform_nco_unit u_dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_ch(lfo_ch),
    .out_ch(sample_ch),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    sample_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      sample_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (rst_n) begin
      if (sample_ch.valid && sample_ch.ready) ledger.check_sample_word(sample_ch.sample_out);
      if (lfo_ch.valid && lfo_ch.ready) ledger.take_lfo_word(lfo_ch.lfo_value);
    end
    if (cycles >= CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  task automatic push_lfo(input logic signed [15:0] v);
    while ($urandom_range(99) < send_idle_pct) begin
      lfo_ch.valid <= 1'b0;
      @(negedge clk);
    end
    lfo_ch.valid <= 1'b1;
    lfo_ch.lfo_value <= v;
    @(posedge clk);
    while (!lfo_ch.ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic drain();
    lfo_ch.valid <= 1'b0;
    do @(negedge clk); while (ledger.pending_samples.size() != 0);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    ledger.write_reg(idx, data);
    @(negedge clk);
  endtask

  task automatic program_regs(input wave_t wave, input bit en, input logic [31:0] step,
                              input logic signed [31:0] fmd, input int pw, input int pwd);
    logic [31:0] junk;
    junk = $urandom();
    cfg_write(REG_WAVE_SELECT, {junk[31:2], wave});
    cfg_write(REG_LFO_ENABLE, {junk[30:0], en});
    cfg_write(REG_PHASE_STEP, step);
    cfg_write(REG_FREQ_MOD_DEPTH, fmd);
    cfg_write(REG_PULSE_WIDTH, {junk[14:0], pw[16:0]});
    cfg_write(REG_PW_MOD_DEPTH, {junk[13:0], pwd[17:0]});
    cfg_write(($urandom_range(1) != 0) ? REG_SPARE_HI : REG_SPARE_LO, $urandom());
    cfg_we <= 1'b0;
  endtask

  initial begin
    int pw, pwd;
    logic [31:0] step;
    logic signed [31:0] fmd;
    logic signed [15:0] lv;
    bit corner;
    ledger = new();
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = REG_WAVE_SELECT;
    cfg_data = '0;
    lfo_ch.valid = 1'b0;
    lfo_ch.lfo_value = '0;
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset values: saw at phase zero, LFO ignored
    push_lfo(16'sh0000);
    push_lfo(16'sh8000);
    drain();
    program_regs(WAVE_TRIANGLE, 1'b0, 32'h4000_0000, 32'sh0, 32768, 0);
    push_lfo(16'sh7FFF);
    push_lfo(16'sh0000);
    push_lfo(-16'sd1);
    push_lfo(16'sh0001);
    drain();
    program_regs(WAVE_SINE, 1'b0, 32'h4000_0000, 32'sh0, 32768, 0);
    repeat (4) push_lfo(16'($urandom()));
    drain();
    // negative increment: phase runs backward
    program_regs(WAVE_SAW, 1'b1, 32'h0, 32'sh8000_0000, 32768, 0);
    push_lfo(16'sh7FFF);
    push_lfo(16'sh7FFF);
    push_lfo(16'sh8000);
    drain();
    // increment past a full cycle
    program_regs(WAVE_SAW, 1'b1, 32'hFFFF_FFFF, 32'sh7FFF_FFFF, 32768, 0);
    push_lfo(16'sh7FFF);
    push_lfo(16'sh7FFF);
    drain();
    program_regs(WAVE_PULSE, 1'b0, 32'h1000_0000, 32'sh0, 0, 0);
    push_lfo(16'sh7FFF);
    push_lfo(16'sh8000);
    drain();
    program_regs(WAVE_PULSE, 1'b0, 32'h3000_0000, 32'sh0, 65536, 0);
    push_lfo(16'sh8000);
    push_lfo(16'sh7FFF);
    drain();
    // pulse width pushed past both rails by the LFO
    program_regs(WAVE_PULSE, 1'b1, 32'h2000_0000, 32'sh0, 32768, -65536);
    push_lfo(16'sh8000);
    push_lfo(16'sh7FFF);
    push_lfo(16'sh4000);

    for (int s = 0; s < SETTINGS_RUN; s++) begin
      drain();
      case (s % 4)
        0: begin send_idle_pct = 0; recv_stall_pct = 0; end
        1: begin send_idle_pct = 75; recv_stall_pct = 0; end
        2: begin send_idle_pct = 0; recv_stall_pct = 75; end
        default: begin send_idle_pct = 32; recv_stall_pct = 32; end
      endcase
      corner = (s % 3 == 2);
      if (corner) begin
        step = s[2] ? 32'h8000_0000 : 32'h0;
        fmd = s[3] ? 32'sh7FFF_FFFF : 32'sh8000_0000;
        pw = s[2] ? 65536 : 0;
        pwd = s[3] ? 65536 : -65536;
      end else begin
        step = ($urandom_range(1) != 0) ? $urandom_range(32'h8000_0000, 0)
                                        : $urandom_range(32'h0100_0000, 0);
        fmd = ($urandom_range(1) != 0) ? $urandom()
                                       : int'($urandom_range(32'h0200_0000, 0)) - 32'sh0100_0000;
        pw = $urandom_range(65536, 0);
        pwd = int'($urandom_range(131072, 0)) - 65536;
      end
      program_regs(wave_t'($urandom_range(3)), corner | ($urandom_range(1) != 0),
                   step, fmd, pw, pwd);
      for (int n = 0; n < WORDS_PER_SETTING; n++) begin
        if (s == 10 && n == WORDS_PER_SETTING / 2) drain();
        case ($urandom_range(7))
          0: lv = 16'sh7FFF;
          1: lv = 16'sh8000;
          default: lv = 16'($urandom());
        endcase
        push_lfo(lv);
      end
    end

    drain();
    repeat (LATENCY * 4) @(negedge clk);
    if (ledger.mismatches == 0 && ledger.pending_samples.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
